// File: sv/osml_pkg.sv
// shared constants for the omniwheel speed mixer
package osml_pkg;

    localparam int LIM_W  = 15;
    localparam int COEF_SHIFT = 14;
    localparam int IN_W   = 16;
    localparam int PROD_W = 32;

    // Q1.14 mixing coefficients (magnitudes; signs applied in the sums)
    localparam logic signed [IN_W-1:0] COEF_A = 16'sd13255;
    localparam logic signed [IN_W-1:0] COEF_B = 16'sd9631;
    localparam logic signed [IN_W-1:0] COEF_C = 16'sd10963;
    localparam logic signed [IN_W-1:0] COEF_D = 16'sd12175;

    localparam logic [LIM_W-1:0] SPEED_LIMIT_RST    = 15'd640;
    localparam logic [LIM_W-1:0] ROTATION_LEVER_RST = 15'd21760;

    localparam logic ADDR_SPEED_LIMIT    = 1'b0;
    localparam logic ADDR_ROTATION_LEVER = 1'b1;

endpackage

// File: sv/osml_front.sv
// front pipeline: mixing products, raw wheel speeds, peak magnitude and limit check
module osml_front
    import osml_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int RAW_W     = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  vel_x,
    input  logic signed [IN_W-1:0]  vel_y,
    input  logic signed [IN_W-1:0]  turn_rate,
    input  logic [LIM_W-1:0]        speed_limit,
    input  logic [LIM_W-1:0]        rotation_lever,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [5*RAW_W:0]        out_entry
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg;

    logic signed [PROD_W-1:0] pax_reg, pby_reg, pcx_reg, pdy_reg, ptr_reg;
    logic signed [RAW_W-1:0]  w_reg [4];
    logic signed [RAW_W-1:0]  w_next [4];
    logic [5*RAW_W:0]         entry_reg, entry_next;

    logic signed [PROD_W-1:0] sum [4];
    logic signed [PROD_W-1:0] turn;
    logic [RAW_W-1:0]         mg [4];
    logic [RAW_W-1:0]         m01, m23, mx;

    assign adv      = !v3_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        sum[0] =  pax_reg + pby_reg;
        sum[1] = -pax_reg + pby_reg;
        sum[2] = -pcx_reg - pdy_reg;
        sum[3] =  pcx_reg - pdy_reg;
        turn   = ptr_reg >>> FRAC_BITS;
        for (int i = 0; i < 4; i++)
        begin
            w_next[i] = RAW_W'(sum[i] >>> COEF_SHIFT) + RAW_W'(turn);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mg[i] = w_reg[i][RAW_W-1] ? RAW_W'(-w_reg[i]) : RAW_W'(w_reg[i]);
        end
        m01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
        m23 = (mg[2] > mg[3]) ? mg[2] : mg[3];
        mx  = (m01 > m23) ? m01 : m23;
        entry_next = {(mx > RAW_W'(speed_limit)), mx,
                      w_reg[3], w_reg[2], w_reg[1], w_reg[0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pax_reg <= PROD_W'(vel_x) * PROD_W'(COEF_A);
            pby_reg <= PROD_W'(vel_y) * PROD_W'(COEF_B);
            pcx_reg <= PROD_W'(vel_x) * PROD_W'(COEF_C);
            pdy_reg <= PROD_W'(vel_y) * PROD_W'(COEF_D);
            ptr_reg <= PROD_W'(turn_rate) * $signed({{(PROD_W-LIM_W){1'b0}}, rotation_lever});
            for (int i = 0; i < 4; i++)
            begin
                w_reg[i] <= w_next[i];
            end
            entry_reg <= entry_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_entry = entry_reg;

endmodule

// File: sv/osml_queue.sv
// two-entry queue between the front pipeline and the scaling unit
module osml_queue
#(
    parameter int W = 121
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// File: sv/osml_back.sv
// back end: scales limited commands by limit/max with four bit-serial dividers
module osml_back
    import osml_pkg::*;
#(
    parameter int RAW_W = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [5*RAW_W:0]       in_entry,
    input  logic [LIM_W-1:0]       speed_limit,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [IN_W-1:0] wheel_out [4],
    output logic                   limited_out
);

    localparam int MP_W  = RAW_W + LIM_W;
    localparam int CNT_W = $clog2(LIM_W + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             out_valid_reg, out_valid_next;
    logic signed [IN_W-1:0] wheel_reg [4];
    logic signed [IN_W-1:0] wheel_next [4];
    logic             lim_reg, lim_next;

    logic [RAW_W-1:0] mag_reg [4];
    logic             neg_reg [4];
    logic [RAW_W-1:0] max_reg;
    logic [MP_W-1:0]  prod_reg [4];
    logic [RAW_W:0]   rem_reg [4];
    logic [LIM_W-1:0] quo_reg [4];

    logic signed [RAW_W-1:0] ew [4];
    logic [RAW_W-1:0] emax;
    logic             elim;
    logic             out_free;
    logic             take;
    logic [RAW_W:0]   rem_sh [4];
    logic             qbit [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ew[i] = in_entry[i*RAW_W +: RAW_W];
        end
        emax = in_entry[4*RAW_W +: RAW_W];
        elim = in_entry[5*RAW_W];
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rem_sh[i] = {rem_reg[i][RAW_W-1:0], prod_reg[i][LIM_W-1]};
            qbit[i]   = (rem_sh[i] >= {1'b0, max_reg});
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        take           = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        lim_next       = lim_reg;
        for (int i = 0; i < 4; i++)
        begin
            wheel_next[i] = wheel_reg[i];
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!elim)
                    begin
                        if (out_free)
                        begin
                            take           = 1'b1;
                            out_valid_next = 1'b1;
                            lim_next       = 1'b0;
                            for (int i = 0; i < 4; i++)
                            begin
                                wheel_next[i] = IN_W'(ew[i]);
                            end
                        end
                    end
                    else
                    begin
                        take       = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
                cnt_next   = CNT_W'(LIM_W + 1);
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    lim_next       = 1'b1;
                    state_next     = ST_IDLE;
                    for (int i = 0; i < 4; i++)
                    begin
                        wheel_next[i] = neg_reg[i] ? -$signed({1'b0, quo_reg[i]})
                                                   :  $signed({1'b0, quo_reg[i]});
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
        for (int i = 0; i < 4; i++)
        begin
            wheel_reg[i] <= wheel_next[i];
        end
        if (take)
        begin
            max_reg <= emax;
            for (int i = 0; i < 4; i++)
            begin
                neg_reg[i] <= ew[i][RAW_W-1];
                mag_reg[i] <= ew[i][RAW_W-1] ? RAW_W'(-ew[i]) : RAW_W'(ew[i]);
            end
        end
        if (state_reg == ST_MUL)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= MP_W'(mag_reg[i]) * MP_W'(speed_limit);
                rem_reg[i]  <= '0;
                quo_reg[i]  <= '0;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (cnt_reg == CNT_W'(LIM_W + 1))
                begin
                    // first step loads the high part, which is already below max
                    rem_reg[i] <= (RAW_W+1)'(prod_reg[i] >> LIM_W);
                end
                else
                begin
                    prod_reg[i] <= prod_reg[i] << 1;
                    quo_reg[i]  <= {quo_reg[i][LIM_W-2:0], qbit[i]};
                    rem_reg[i]  <= qbit[i] ? (rem_sh[i] - {1'b0, max_reg}) : rem_sh[i];
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign limited_out = lim_reg;
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            wheel_out[i] = wheel_reg[i];
        end
    end

endmodule

// File: sv/omniwheel_speed_mix_limit.sv
// Omniwheel speed mixer with desaturation. A body command (vel_x, vel_y, turn_rate, signed
// Q8.8) is mixed into four wheel speeds by a fixed Q1.14 matrix plus rotation_lever times
// turn_rate; when the largest wheel magnitude exceeds speed_limit all four are scaled by
// limit/max, truncated toward zero, and was_limited is set. A command passes a three-stage
// front pipeline and a two-entry queue; one that needs no scaling goes straight to the
// output registers, and such commands flow at one per cycle while the outputs are popped. A
// scaled command holds the four parallel bit-serial dividers through take, multiply, load,
// the 15-bit quotient and output; no new command is taken before it is output, so the divider
// sets the rate for commands that hit the limit.
module omniwheel_speed_mix_limit
    import osml_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic signed [IN_W-1:0] vel_x,
    input  logic signed [IN_W-1:0] vel_y,
    input  logic signed [IN_W-1:0] turn_rate,
    output logic                   empty,
    input  logic                   pop,
    output logic signed [IN_W-1:0] wheel_one,
    output logic signed [IN_W-1:0] wheel_two,
    output logic signed [IN_W-1:0] wheel_three,
    output logic signed [IN_W-1:0] wheel_four,
    output logic                   was_limited,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int RAW_W   = (31 - FRAC_BITS > 17) ? (32 - FRAC_BITS) : 18;
    localparam int ENTRY_W = 5 * RAW_W + 1;

    logic [LIM_W-1:0] speed_limit_reg, rotation_lever_reg;
    logic             in_ready;
    logic             f_valid, f_ready, b_valid, b_ready, o_valid;
    logic [ENTRY_W-1:0] f_entry, b_entry;
    logic signed [IN_W-1:0] wheels [4];

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg    <= SPEED_LIMIT_RST;
            rotation_lever_reg <= ROTATION_LEVER_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                ADDR_SPEED_LIMIT:    speed_limit_reg    <= pwdata[LIM_W-1:0];
                ADDR_ROTATION_LEVER: rotation_lever_reg <= pwdata[LIM_W-1:0];
                default:             speed_limit_reg    <= speed_limit_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == ADDR_ROTATION_LEVER) ? {17'd0, rotation_lever_reg}
                                                      : {17'd0, speed_limit_reg};

    assign full = !in_ready;

    osml_front #(.FRAC_BITS(FRAC_BITS), .RAW_W(RAW_W)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (push),
        .in_ready       (in_ready),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .turn_rate      (turn_rate),
        .speed_limit    (speed_limit_reg),
        .rotation_lever (rotation_lever_reg),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .out_entry      (f_entry)
    );

    osml_queue #(.W(ENTRY_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_entry),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_entry)
    );

    osml_back #(.RAW_W(RAW_W)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (b_valid),
        .in_ready    (b_ready),
        .in_entry    (b_entry),
        .speed_limit (speed_limit_reg),
        .out_valid   (o_valid),
        .out_ready   (pop),
        .wheel_out   (wheels),
        .limited_out (was_limited)
    );

    assign empty       = !o_valid;
    assign wheel_one   = wheels[0];
    assign wheel_two   = wheels[1];
    assign wheel_three = wheels[2];
    assign wheel_four  = wheels[3];

endmodule
